// File: hdl/kqpb_pkg.sv
// ----------------------------------------------------------------------------
// Key-queued pulse burst generator package
// Shared constants, register indexes and the structs passed between modules.
// ----------------------------------------------------------------------------
package kqpb_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

  localparam int NUM_KEYS    = 4;
  localparam int CODE_W      = 2;
  localparam int DROP_W      = 3;

  localparam int HIGH_W      = 8;
  localparam int LOW_W       = 8;
  localparam int GAP_W       = 10;
  localparam int COUNT_W     = 8;
  localparam int PHASE_W     = 9;
  localparam int SUM_W       = 10;

  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 10;

  localparam int DESC_DEPTH  = 2;
  localparam int DESC_PTR_W  = (DESC_DEPTH > 1) ? $clog2(DESC_DEPTH) : 1;
  localparam int DESC_CNT_W  = $clog2(DESC_DEPTH + 1);

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 24;

  localparam logic [HIGH_W-1:0]  HIGH_RESET   = 8'd2;
  localparam logic [LOW_W-1:0]   LOW_RESET    = 8'd3;
  localparam logic [GAP_W-1:0]   GAP_RESET    = 10'd51;
  localparam logic [COUNT_W-1:0] COUNT0_RESET = 8'd10;
  localparam logic [COUNT_W-1:0] COUNT1_RESET = 8'd1;
  localparam logic [COUNT_W-1:0] COUNT2_RESET = 8'd2;
  localparam logic [COUNT_W-1:0] COUNT3_RESET = 8'd3;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_HIGH_TICKS = 3'd0,
    REG_LOW_TICKS  = 3'd1,
    REG_GAP_TICKS  = 3'd2,
    REG_COUNT_KEY0 = 3'd3,
    REG_COUNT_KEY1 = 3'd4,
    REG_COUNT_KEY2 = 3'd5,
    REG_COUNT_KEY3 = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic [HIGH_W-1:0]                  high_ticks;
    logic [LOW_W-1:0]                   low_ticks;
    logic [GAP_W-1:0]                   gap_ticks;
    logic [NUM_KEYS-1:0][COUNT_W-1:0]   key_counts;
  } cfg_t;

  typedef struct packed {
    logic [NUM_KEYS-1:0] rising;
  } desc_t;

  typedef struct packed {
    logic [COUNT_W-1:0] pulses_remaining;
    logic [DROP_W-1:0]  dropped_keys;
    logic [4:0]         queued_keys;
    logic               busy_flag;
    logic               pulse_level;
  } result_t;

endpackage

// File: hdl/kqpb_fifo.sv
// ----------------------------------------------------------------------------
// Tick descriptor queue
// Two-entry queue that decouples the edge detector from the burst engine.
// ----------------------------------------------------------------------------
module kqpb_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  kqpb_pkg::desc_t push_data,
  output logic            push_ready,
  input  logic            pop,
  output logic            pop_valid,
  output kqpb_pkg::desc_t pop_data
);

  kqpb_pkg::desc_t                      entries [kqpb_pkg::DESC_DEPTH];
  logic [kqpb_pkg::DESC_PTR_W-1:0]      wr_ptr;
  logic [kqpb_pkg::DESC_PTR_W-1:0]      rd_ptr;
  logic [kqpb_pkg::DESC_CNT_W-1:0]      count;
  logic                                 do_push;
  logic                                 do_pop;

  assign push_ready = count < kqpb_pkg::DESC_CNT_W'(kqpb_pkg::DESC_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: hdl/kqpb_front.sv
// ----------------------------------------------------------------------------
// Key edge detector
// Accepts input words, finds rising key edges and queues one descriptor a tick.
// ----------------------------------------------------------------------------
module kqpb_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic [kqpb_pkg::NUM_KEYS-1:0]       in_keys,
  output logic                                in_ready,
  output logic                                desc_push,
  output kqpb_pkg::desc_t                     desc_data,
  input  logic                                desc_ready
);

  logic [kqpb_pkg::NUM_KEYS-1:0] previous_keys;

  assign in_ready         = desc_ready;
  assign desc_push        = in_valid && desc_ready;
  assign desc_data.rising = in_keys & ~previous_keys;

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_keys <= '0;
    end else if (desc_push) begin
      previous_keys <= in_keys;
    end
  end

endmodule

// File: hdl/kqpb_back.sv
// ----------------------------------------------------------------------------
// Burst engine
// Pushes key codes into the key queue, runs one generator step a tick and
// holds the result word until it is taken.
// ----------------------------------------------------------------------------
module kqpb_back (
  input  logic              clk,
  input  logic              rst,
  input  kqpb_pkg::cfg_t    cfg,
  input  logic              desc_valid,
  input  kqpb_pkg::desc_t   desc_data,
  output logic              desc_pop,
  output logic              out_valid,
  output kqpb_pkg::result_t out_data,
  input  logic              out_ready
);

  logic [kqpb_pkg::CODE_W-1:0]  key_queue [kqpb_pkg::QUEUE_DEPTH];
  logic [kqpb_pkg::QPTR_W-1:0]  queue_head;
  logic [kqpb_pkg::QPTR_W-1:0]  queue_tail;
  logic [kqpb_pkg::QFILL_W-1:0] queue_fill;
  logic                         running;
  logic [kqpb_pkg::PHASE_W-1:0] phase_ticks;
  logic [kqpb_pkg::COUNT_W-1:0] pulses_left;
  logic [kqpb_pkg::GAP_W-1:0]   gap_count;
  logic                         pin_state;

  logic [kqpb_pkg::CODE_W-1:0]  key_queue_next [kqpb_pkg::QUEUE_DEPTH];
  logic [kqpb_pkg::QPTR_W-1:0]  queue_head_next;
  logic [kqpb_pkg::QPTR_W-1:0]  queue_tail_next;
  logic [kqpb_pkg::QFILL_W-1:0] queue_fill_next;
  logic                         running_next;
  logic [kqpb_pkg::PHASE_W-1:0] phase_ticks_next;
  logic [kqpb_pkg::COUNT_W-1:0] pulses_left_next;
  logic [kqpb_pkg::GAP_W-1:0]   gap_count_next;
  logic                         pin_state_next;
  logic [kqpb_pkg::DROP_W-1:0]  dropped;
  logic [kqpb_pkg::CODE_W-1:0]  code;
  logic [kqpb_pkg::SUM_W-1:0]   phase_inc;
  logic [kqpb_pkg::SUM_W-1:0]   high_ext;
  logic [kqpb_pkg::SUM_W-1:0]   period;
  logic                         fire;

  localparam logic [kqpb_pkg::QPTR_W-1:0]  QPTR_LAST =
    kqpb_pkg::QPTR_W'(kqpb_pkg::QUEUE_DEPTH - 1);
  localparam logic [kqpb_pkg::QFILL_W-1:0] QFILL_FULL =
    kqpb_pkg::QFILL_W'(kqpb_pkg::QUEUE_DEPTH);

  assign fire     = desc_valid && (!out_valid || out_ready);
  assign desc_pop = fire;
  assign high_ext = kqpb_pkg::SUM_W'(cfg.high_ticks);
  assign period   = kqpb_pkg::SUM_W'(cfg.high_ticks) + kqpb_pkg::SUM_W'(cfg.low_ticks);
  assign phase_inc = kqpb_pkg::SUM_W'(phase_ticks) + 1'b1;

  always_comb begin
    key_queue_next   = key_queue;
    queue_head_next  = queue_head;
    queue_tail_next  = queue_tail;
    queue_fill_next  = queue_fill;
    running_next     = running;
    phase_ticks_next = phase_ticks;
    pulses_left_next = pulses_left;
    gap_count_next   = gap_count;
    pin_state_next   = pin_state;
    dropped          = '0;
    code             = '0;

    // Edges enter the queue in key order, lowest key first.
    for (int i = 0; i < kqpb_pkg::NUM_KEYS; i++) begin
      if (desc_data.rising[i]) begin
        if (queue_fill_next < QFILL_FULL) begin
          key_queue_next[queue_tail_next] = kqpb_pkg::CODE_W'(i);
          queue_tail_next = (queue_tail_next == QPTR_LAST) ? '0 : queue_tail_next + 1'b1;
          queue_fill_next = queue_fill_next + 1'b1;
        end else begin
          dropped = dropped + 1'b1;
        end
      end
    end

    if (!running && queue_fill_next != '0) begin
      code             = key_queue_next[queue_head];
      queue_head_next  = (queue_head == QPTR_LAST) ? '0 : queue_head + 1'b1;
      queue_fill_next  = queue_fill_next - 1'b1;
      running_next     = 1'b1;
      pulses_left_next = cfg.key_counts[code];
    end

    if (running_next) begin
      if (pulses_left_next != '0) begin
        if (phase_inc <= high_ext) begin
          pin_state_next = 1'b1;
        end else if (phase_inc <= period) begin
          pin_state_next = 1'b0;
        end
        if (phase_inc >= period) begin
          phase_ticks_next = '0;
          pulses_left_next = pulses_left_next - 1'b1;
        end else begin
          phase_ticks_next = phase_inc[kqpb_pkg::PHASE_W-1:0];
        end
      end else if (gap_count < cfg.gap_ticks) begin
        pin_state_next = 1'b0;
        gap_count_next = gap_count + 1'b1;
      end else begin
        gap_count_next   = '0;
        running_next     = 1'b0;
        phase_ticks_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      key_queue                 <= key_queue_next;
      out_data.pulse_level      <= pin_state_next;
      out_data.busy_flag        <= running_next;
      out_data.queued_keys      <= 5'(queue_fill_next);
      out_data.dropped_keys     <= dropped;
      out_data.pulses_remaining <= pulses_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      queue_head  <= '0;
      queue_tail  <= '0;
      queue_fill  <= '0;
      running     <= 1'b0;
      phase_ticks <= '0;
      pulses_left <= '0;
      gap_count   <= '0;
      pin_state   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (fire) begin
        queue_head  <= queue_head_next;
        queue_tail  <= queue_tail_next;
        queue_fill  <= queue_fill_next;
        running     <= running_next;
        phase_ticks <= phase_ticks_next;
        pulses_left <= pulses_left_next;
        gap_count   <= gap_count_next;
        pin_state   <= pin_state_next;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid   <= 1'b0;
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    queue_fill <= QFILL_FULL)
    else $error("Key queue fill exceeds its depth.");

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    !running |-> (pulses_left == '0 && phase_ticks == '0 && gap_count == '0))
    else $error("Idle generator holds leftover burst state.");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.dropped_keys != '0) |-> (queue_fill >= QFILL_FULL - 1'b1))
    else $error("Key edges reported dropped while the queue had room.");

endmodule

// File: hdl/key_queued_pulse_burst_generator.sv
// ----------------------------------------------------------------------------
// Key-queued pulse burst generator
// Queues key press codes and plays a pulse burst for each one in turn.
// ----------------------------------------------------------------------------
// Each input word is one timebase tick carrying four key levels, and each
// accepted word yields exactly one result word. The block sustains one word
// per clock cycle while m_tready is high: the burst engine does the key queue
// update and the pulse counter step of a tick combinationally. An accepted
// word passes through the descriptor FIFO and then into the burst engine's
// output register. Configuration registers take effect on the next tick and
// should be written only while no word is in flight.
module key_queued_pulse_burst_generator (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // [3:0] key_levels, [7:4] zero
  input  logic [kqpb_pkg::IN_TDATA_W-1:0]      s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // [0] pulse_level, [1] busy_flag, [6:2] queued_keys, [9:7] dropped_keys,
  // [17:10] pulses_remaining, [23:18] zero
  output logic [kqpb_pkg::OUT_TDATA_W-1:0]     m_tdata,
  input  logic                                 cfg_we,
  input  logic [kqpb_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [kqpb_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  kqpb_pkg::cfg_t    cfg;
  kqpb_pkg::desc_t   front_desc;
  kqpb_pkg::desc_t   back_desc;
  kqpb_pkg::result_t result;
  logic              front_push;
  logic              fifo_ready;
  logic              fifo_valid;
  logic              back_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.high_ticks    <= kqpb_pkg::HIGH_RESET;
      cfg.low_ticks     <= kqpb_pkg::LOW_RESET;
      cfg.gap_ticks     <= kqpb_pkg::GAP_RESET;
      cfg.key_counts[0] <= kqpb_pkg::COUNT0_RESET;
      cfg.key_counts[1] <= kqpb_pkg::COUNT1_RESET;
      cfg.key_counts[2] <= kqpb_pkg::COUNT2_RESET;
      cfg.key_counts[3] <= kqpb_pkg::COUNT3_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        kqpb_pkg::REG_HIGH_TICKS: cfg.high_ticks    <= cfg_wdata[kqpb_pkg::HIGH_W-1:0];
        kqpb_pkg::REG_LOW_TICKS:  cfg.low_ticks     <= cfg_wdata[kqpb_pkg::LOW_W-1:0];
        kqpb_pkg::REG_GAP_TICKS:  cfg.gap_ticks     <= cfg_wdata[kqpb_pkg::GAP_W-1:0];
        kqpb_pkg::REG_COUNT_KEY0: cfg.key_counts[0] <= cfg_wdata[kqpb_pkg::COUNT_W-1:0];
        kqpb_pkg::REG_COUNT_KEY1: cfg.key_counts[1] <= cfg_wdata[kqpb_pkg::COUNT_W-1:0];
        kqpb_pkg::REG_COUNT_KEY2: cfg.key_counts[2] <= cfg_wdata[kqpb_pkg::COUNT_W-1:0];
        kqpb_pkg::REG_COUNT_KEY3: cfg.key_counts[3] <= cfg_wdata[kqpb_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  kqpb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_keys    (s_tdata[kqpb_pkg::NUM_KEYS-1:0]),
    .in_ready   (s_tready),
    .desc_push  (front_push),
    .desc_data  (front_desc),
    .desc_ready (fifo_ready)
  );

  kqpb_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (front_push),
    .push_data  (front_desc),
    .push_ready (fifo_ready),
    .pop        (back_pop),
    .pop_valid  (fifo_valid),
    .pop_data   (back_desc)
  );

  kqpb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .desc_valid (fifo_valid),
    .desc_data  (back_desc),
    .desc_pop   (back_pop),
    .out_valid  (m_tvalid),
    .out_data   (result),
    .out_ready  (m_tready)
  );

  assign m_tdata = {6'b0, result.pulses_remaining, result.dropped_keys,
                    result.queued_keys, result.busy_flag, result.pulse_level};

endmodule
